// ----- design/kdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// kdlp_pkg: shared types and constants for the keypad debounce block
// Register map, reset values and default sizes used by the interfaces and
// the core.
// ----------------------------------------------------------------------------
package kdlp_pkg;

  // Default sizes
  localparam int unsigned NumKeys    = 15;
  localparam int unsigned TimerWidth = 16;

  // Configuration port sizes
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned RegWidth     = 16;
  localparam int unsigned BoostWidth   = 8;

  typedef logic [CfgAddrWidth-1:0] cfg_addr_t;
  typedef logic [CfgDataWidth-1:0] cfg_data_t;
  typedef logic [RegWidth-1:0]     tick_reg_t;
  typedef logic [BoostWidth-1:0]   boost_cnt_t;

  // Register indexes
  typedef enum logic [CfgAddrWidth-1:0] {
    RegDebounceTicks  = 3'd0,
    RegLongTicks      = 3'd1,
    RegRepeatTicks    = 3'd2,
    RegBoostThreshold = 3'd3,
    RegBoostTicks     = 3'd4
  } cfg_reg_e;

  // Register reset values
  localparam tick_reg_t  DebounceTicksRst  = 16'd50;
  localparam tick_reg_t  LongTicksRst      = 16'd1000;
  localparam tick_reg_t  RepeatTicksRst    = 16'd200;
  localparam boost_cnt_t BoostThresholdRst = 8'd10;
  localparam tick_reg_t  BoostTicksRst     = 16'd50;

endpackage

// ----- design/kdlp_intf.sv -----
// ----------------------------------------------------------------------------
// kdlp interfaces: handshake channels of the keypad debounce block
// Key sample input, event result output and register write channel.
// ----------------------------------------------------------------------------

// Key sample channel: one item per scan tick
interface kdlp_key_if #(
  parameter int unsigned NUM_KEYS = kdlp_pkg::NumKeys
);
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] key_sample;

  modport source (output valid, output key_sample, input ready);
  modport sink   (input valid, input key_sample, output ready);
endinterface

// Event result channel
interface kdlp_evt_if #(
  parameter int unsigned NUM_KEYS = kdlp_pkg::NumKeys
);
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] event_keys;
  logic                long_flag;

  modport source (output valid, output event_keys, output long_flag, input ready);
  modport sink   (input valid, input event_keys, input long_flag, output ready);
endinterface

// Register write channel
interface kdlp_cfg_if;
  logic                valid;
  logic                ready;
  kdlp_pkg::cfg_addr_t addr;
  kdlp_pkg::cfg_data_t data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- design/keypad_debounce_longpress_core.sv -----
// ----------------------------------------------------------------------------
// keypad_debounce_longpress_core: key debounce with long press and repeat
// Turns scan ticks of key levels into release and long-press events.
// ----------------------------------------------------------------------------
// Each accepted item is one scan tick and yields exactly one result item.
// The block takes one item per clock cycle unless the result side stalls:
// the tick is folded into the press state by one pass of mask and countdown
// logic, and the result lands in a single result register in the next cycle.
// The input is ready whenever the result register is empty or being taken
// in the same cycle; a stall on the result side holds off the input only for
// as long as that register stays full. Register writes are always accepted.
module keypad_debounce_longpress_core #(
  parameter int unsigned NUM_KEYS    = kdlp_pkg::NumKeys,
  parameter int unsigned TIMER_WIDTH = kdlp_pkg::TimerWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kdlp_key_if.sink   in_i,
  kdlp_evt_if.source res_o,
  kdlp_cfg_if.sink   cfg_i
);
  import kdlp_pkg::*;

  typedef logic [NUM_KEYS-1:0]    key_mask_t;
  typedef logic [TIMER_WIDTH-1:0] timer_t;

  // Configuration registers
  tick_reg_t  debounce_ticks_q, long_ticks_q, repeat_ticks_q, boost_ticks_q;
  boost_cnt_t boost_threshold_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q  <= DebounceTicksRst;
      long_ticks_q      <= LongTicksRst;
      repeat_ticks_q    <= RepeatTicksRst;
      boost_threshold_q <= BoostThresholdRst;
      boost_ticks_q     <= BoostTicksRst;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.addr))
        RegDebounceTicks:  debounce_ticks_q  <= tick_reg_t'(cfg_i.data);
        RegLongTicks:      long_ticks_q      <= tick_reg_t'(cfg_i.data);
        RegRepeatTicks:    repeat_ticks_q    <= tick_reg_t'(cfg_i.data);
        RegBoostThreshold: boost_threshold_q <= cfg_i.data[BoostWidth-1:0];
        RegBoostTicks:     boost_ticks_q     <= tick_reg_t'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Countdown load values, fitted to the timer width
  timer_t load_deb, load_long, load_rep, load_boost;
  assign load_deb   = TIMER_WIDTH'(debounce_ticks_q);
  assign load_long  = TIMER_WIDTH'(long_ticks_q);
  assign load_rep   = TIMER_WIDTH'(repeat_ticks_q);
  assign load_boost = TIMER_WIDTH'(boost_ticks_q);

  // Press state
  key_mask_t  down_q, down_d;
  logic       long_q, long_d;
  boost_cnt_t boost_q, boost_d;
  timer_t     deb_q, deb_d, hold_q, hold_d;

  // Result register
  logic       res_valid_q;
  key_mask_t  res_keys_q, res_keys_d;

  logic in_acc;
  assign in_i.ready = !res_valid_q || res_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // Next press state for one tick
  timer_t         deb_dec, hold_dec;
  logic           changed, fire;
  logic [BoostWidth:0] boost_inc;

  always_comb begin
    deb_dec    = (deb_q != '0) ? deb_q - 1'b1 : deb_q;
    hold_dec   = (hold_q != '0) ? hold_q - 1'b1 : hold_q;
    changed    = (in_i.key_sample != down_q);
    down_d     = '0;
    long_d     = 1'b0;
    boost_d    = '0;
    deb_d      = load_deb;
    hold_d     = load_long;
    res_keys_d = '0;
    fire       = 1'b0;
    boost_inc  = '0;
    if (in_i.key_sample != '0) begin
      // Key(s) down: a new chord restarts both countdowns
      long_d  = changed ? 1'b0 : long_q;
      boost_d = changed ? '0 : boost_q;
      deb_d   = changed ? load_deb : deb_dec;
      hold_d  = changed ? load_long : hold_dec;
      down_d  = down_q | in_i.key_sample;
      fire    = (hold_d == '0) && (!long_d || (repeat_ticks_q != '0));
      boost_inc = {1'b0, boost_d} + 1'b1;
      if (fire) begin
        res_keys_d = down_d;
        long_d     = 1'b1;
        if ((boost_threshold_q != '0) && (boost_inc > {1'b0, boost_threshold_q})) begin
          boost_d = boost_threshold_q;
          hold_d  = load_boost;
        end else begin
          if (boost_threshold_q != '0) begin
            boost_d = boost_inc[BoostWidth-1:0];
          end
          hold_d = load_rep;
        end
      end
    end else begin
      // All keys up: report release once the debounce countdown has run out, unless it was a long press
      if ((deb_dec == '0) && !long_q) begin
        res_keys_d = down_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q      <= '0;
      long_q      <= 1'b0;
      boost_q     <= '0;
      deb_q       <= '0;
      hold_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        down_q  <= down_d;
        long_q  <= long_d;
        boost_q <= boost_d;
        deb_q   <= deb_d;
        hold_q  <= hold_d;
      end
      if (in_acc) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  logic res_long_q;
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_keys_q <= res_keys_d;
      res_long_q <= long_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.event_keys = res_keys_q;
  assign res_o.long_flag  = res_long_q;

  // Checks
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> res_o.valid)
    else $error("accepted item produced no result");

  a_release_not_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.key_sample == '0) |=> !res_o.long_flag && (down_q == '0))
    else $error("release left long flag or down mask set");

  a_event_is_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.key_sample != '0) |=>
      (res_o.event_keys == '0) || (res_o.event_keys == down_q))
    else $error("long-press event differs from down mask");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> res_o.valid && !res_o.ready)
    else $error("input held off without a stalled result");

endmodule
